// ===== design/assert_macros.svh =====
// Assertion helpers shared by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every clock edge outside reset.
`define PCS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Implication with the consequent checked in the next cycle.
`define PCS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ===== design/pcs_pkg.sv =====
`default_nettype none
package pcs_pkg;
  typedef enum logic [2:0] {
    ST_IDLE, ST_DIV_START, ST_DIV_WAIT, ST_EMIT
  } pcs_state_t;

  typedef enum logic [1:0] {
    KIND_MIN = 2'd0, KIND_MAX = 2'd1, KIND_CENTROID = 2'd2, KIND_AVERAGES = 2'd3
  } pcs_kind_t;

  localparam logic OP_POINT  = 1'b0;
  localparam logic OP_REPORT = 1'b1;

  localparam logic [1:0] CFG_USE_CONFIDENCE = 2'd0;
  localparam logic [1:0] CFG_USE_SCALE      = 2'd1;
  localparam logic [1:0] CFG_USE_VISIBILITY = 2'd2;

  // 1e-9 in Q48.48, rounded up.
  localparam logic [95:0] VOL_EPS_Q48 = 96'd281475;
  localparam logic [47:0] DENS_MAX    = {48{1'b1}};

  // Division job numbers in the order the report needs them.
  localparam int unsigned NUM_JOBS = 7;
  typedef logic [2:0] pcs_job_t;
  localparam pcs_job_t JOB_CX = 3'd0;
  localparam pcs_job_t JOB_CY = 3'd1;
  localparam pcs_job_t JOB_CZ = 3'd2;
  localparam pcs_job_t JOB_CONF = 3'd3;
  localparam pcs_job_t JOB_SCALE = 3'd4;
  localparam pcs_job_t JOB_VIEWS = 3'd5;
  localparam pcs_job_t JOB_DENS = 3'd6;

  // Controller to datapath.
  typedef struct packed {
    logic     accumulate;
    logic     clear;
    logic     div_start;
    pcs_job_t job;
    logic     div_store;
    logic     out_load;
    logic     [1:0] kind;
  } pcs_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic div_done;
    logic empty;
  } pcs_status_t;
endpackage
`default_nettype wire

// ===== design/pcs_if.sv =====
`default_nettype none
interface pcs_stream_if #(parameter int unsigned W = 8) ();
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== design/pcs_divider.sv =====
`default_nettype none
// Unsigned restoring divider, one quotient bit per cycle, 128-bit dividend.
// The overflow flag is raised when the quotient does not fit in 48 bits.
module pcs_divider (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         start,
  input  wire logic [127:0] dividend,
  input  wire logic [95:0]  divisor,
  output logic              done,
  output logic [63:0]       quotient,
  output logic              overflow
);
  logic [127:0] num_r, num_nxt;
  logic [96:0]  rem_r, rem_nxt;
  logic [95:0]  div_r;
  logic [63:0]  q_r, q_nxt;
  logic         ovf_r, ovf_nxt;
  logic [7:0]   cnt_r, cnt_nxt;
  logic         busy_r, busy_nxt;
  logic [96:0]  shifted;
  logic [97:0]  diff;

  always_comb begin
    num_nxt  = num_r;
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    ovf_nxt  = ovf_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    shifted  = {rem_r[95:0], num_r[127]};
    diff     = {1'b0, shifted} - {2'b00, div_r};
    if (start) begin
      num_nxt  = dividend;
      rem_nxt  = '0;
      q_nxt    = '0;
      ovf_nxt  = 1'b0;
      cnt_nxt  = 8'd128;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      num_nxt = {num_r[126:0], 1'b0};
      if (!diff[97]) begin
        rem_nxt = diff[96:0];
      end else begin
        rem_nxt = shifted;
      end
      if (q_r[63:47] != '0) ovf_nxt = 1'b1;
      q_nxt = {q_r[62:0], ~diff[97]};
      cnt_nxt = cnt_r - 8'd1;
      if (cnt_r == 8'd1) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    num_r <= num_nxt;
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    ovf_r <= ovf_nxt;
    if (start) div_r <= divisor;
  end

  assign done     = busy_r && (cnt_r == 8'd1);
  assign quotient = q_nxt;
  assign overflow = ovf_nxt || (q_nxt[63:48] != '0);
endmodule
`default_nettype wire

// ===== design/pcs_datapath.sv =====
`default_nettype none
module pcs_datapath #(
  parameter int unsigned CW = 25,
  parameter logic [32:0] MAX_PTS = 33'd16777216
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire pcs_pkg::pcs_cmd_t   cmd,
  output pcs_pkg::pcs_status_t     status,
  input  wire logic                use_conf,
  input  wire logic                use_scale,
  input  wire logic                use_vis,
  input  wire logic signed [31:0]  pos_x,
  input  wire logic signed [31:0]  pos_y,
  input  wire logic signed [31:0]  pos_z,
  input  wire logic [15:0]         conf,
  input  wire logic [31:0]         pscale,
  input  wire logic [7:0]          views,
  output logic [1:0]               o_kind,
  output logic signed [31:0]       o_a,
  output logic signed [31:0]       o_b,
  output logic signed [31:0]       o_c,
  output logic [24:0]              o_total,
  output logic [47:0]              o_dens,
  output logic                     o_last
);
  import pcs_pkg::*;

  logic [CW-1:0]        cnt_r;
  logic signed [31:0]   min_r [3];
  logic signed [31:0]   max_r [3];
  logic signed [55:0]   sum_r [3];
  logic [39:0]          csum_r;
  logic [55:0]          ssum_r;
  logic [31:0]          vsum_r;
  logic signed [31:0]   cen_r [3];
  logic [31:0]          avg_r [3];
  logic [47:0]          dens_r;
  logic [31:0]          ext_r [3];
  logic [63:0]          vol_ab_r;
  logic [63:0]          vol_lo_r;
  logic [63:0]          vol_hi_r;
  logic [95:0]          vol_r;
  logic signed [31:0]   p [3];
  logic [127:0]         dividend;
  logic [95:0]          divisor;
  logic                 neg;
  logic [55:0]          sabs;
  logic                 div_done, div_ovf;
  logic [63:0]          quo;
  logic [31:0]          q32;
  logic                 full;
  logic [CW:0]          cnt_ext;

  assign p[0] = pos_x;
  assign p[1] = pos_y;
  assign p[2] = pos_z;
  assign cnt_ext = {1'b0, cnt_r};
  assign full = ({{(33 > CW + 1 ? 33 - CW - 1 : 0){1'b0}}, cnt_ext} >= MAX_PTS);

  // Sign-magnitude operands for the current job.
  always_comb begin
    neg  = 1'b0;
    sabs = '0;
    dividend = '0;
    divisor  = {{(96 - CW){1'b0}}, cnt_r};
    case (cmd.job)
      JOB_CX, JOB_CY, JOB_CZ: begin
        neg  = sum_r[cmd.job[1:0]][55];
        sabs = neg ? 56'(-sum_r[cmd.job[1:0]]) : sum_r[cmd.job[1:0]];
        dividend = {72'd0, sabs};
      end
      JOB_CONF:  dividend = {88'd0, csum_r};
      JOB_SCALE: dividend = {72'd0, ssum_r};
      JOB_VIEWS: dividend = {80'd0, vsum_r, 16'd0};
      JOB_DENS: begin
        dividend = {{(64 - CW){1'b0}}, cnt_r, 64'd0};
        divisor  = vol_r;
      end
      default: dividend = '0;
    endcase
  end

  pcs_divider u_div (
    .clk(clk), .rst_n(rst_n), .start(cmd.div_start), .dividend(dividend),
    .divisor(divisor), .done(div_done), .quotient(quo), .overflow(div_ovf)
  );

  assign q32 = neg ? 32'(-quo[31:0]) : quo[31:0];

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      cnt_r  <= '0;
      csum_r <= '0;
      ssum_r <= '0;
      vsum_r <= '0;
      for (int k = 0; k < 3; k++) begin
        min_r[k] <= '0;
        max_r[k] <= '0;
        sum_r[k] <= '0;
      end
    end else if (cmd.accumulate && !full) begin
      for (int k = 0; k < 3; k++) begin
        if (cnt_r == '0 || p[k] < min_r[k]) min_r[k] <= p[k];
        if (cnt_r == '0 || p[k] > max_r[k]) max_r[k] <= p[k];
        sum_r[k] <= sum_r[k] + 56'(p[k]);
      end
      csum_r <= csum_r + 40'(conf);
      ssum_r <= ssum_r + 56'(pscale);
      vsum_r <= vsum_r + 32'(views);
      cnt_r  <= cnt_r + 1'b1;
    end
    // Volume pipeline: extents, the x-y product, two 64-bit partial products of its
    // 32-bit halves with the z extent, then their sum.
    for (int k = 0; k < 3; k++) begin
      ext_r[k] <= 32'(max_r[k] - min_r[k]);
    end
    vol_ab_r <= 64'(ext_r[0] * ext_r[1]);
    vol_lo_r <= 64'(vol_ab_r[31:0] * ext_r[2]);
    vol_hi_r <= 64'(vol_ab_r[63:32] * ext_r[2]);
    vol_r    <= {32'd0, vol_lo_r} + {vol_hi_r, 32'd0};
    if (cmd.div_store) begin
      case (cmd.job)
        JOB_CX, JOB_CY, JOB_CZ: cen_r[cmd.job[1:0]] <= q32;
        JOB_CONF:  avg_r[0] <= use_conf ? quo[31:0] : 32'd0;
        JOB_SCALE: avg_r[1] <= !use_scale ? 32'd0 :
                               (quo[63:31] != '0) ? 32'h7FFF_FFFF : quo[31:0];
        JOB_VIEWS: avg_r[2] <= use_vis ? quo[31:0] : 32'd0;
        JOB_DENS:  dens_r <= (vol_r < VOL_EPS_Q48) ? 48'd0 :
                             div_ovf ? DENS_MAX : quo[47:0];
        default: dens_r <= dens_r;
      endcase
    end
    if (cmd.out_load) begin
      o_kind  <= cmd.kind;
      o_last  <= (cmd.kind == KIND_AVERAGES);
      o_total <= 25'(cnt_r);
      o_dens  <= (cnt_r == '0) ? 48'd0 : dens_r;
      // An empty cloud reports zero everywhere; the divider results are
      // meaningless with a zero count.
      if (cnt_r == '0) begin
        o_a <= '0; o_b <= '0; o_c <= '0;
      end else begin
        case (cmd.kind)
          KIND_MIN: begin
            o_a <= min_r[0]; o_b <= min_r[1]; o_c <= min_r[2];
          end
          KIND_MAX: begin
            o_a <= max_r[0]; o_b <= max_r[1]; o_c <= max_r[2];
          end
          KIND_CENTROID: begin
            o_a <= cen_r[0]; o_b <= cen_r[1]; o_c <= cen_r[2];
          end
          default: begin
            o_a <= avg_r[0]; o_b <= avg_r[1]; o_c <= avg_r[2];
          end
        endcase
      end
    end
  end

  assign status = '{div_done: div_done, empty: (cnt_r == '0)};
endmodule
`default_nettype wire

// ===== design/pcs_ctrl.sv =====
`default_nettype none
module pcs_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  input  wire logic                 in_op,
  output logic                      in_ready,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  input  wire pcs_pkg::pcs_status_t status,
  output pcs_pkg::pcs_cmd_t         cmd
);
  import pcs_pkg::*;

  pcs_state_t state_r, state_nxt;
  pcs_job_t   job_r, job_nxt;
  logic [1:0] kind_r, kind_nxt;
  logic [1:0] wait_r, wait_nxt;
  logic       ov_r, ov_nxt;
  logic       take;

  assign take = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    job_nxt   = job_r;
    kind_nxt  = kind_r;
    wait_nxt  = wait_r;
    ov_nxt    = ov_r;
    if (out_valid && out_ready) ov_nxt = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (take && in_op == OP_REPORT) begin
          job_nxt   = JOB_CX;
          wait_nxt  = 2'd3;
          state_nxt = ST_DIV_START;
        end
      end
      ST_DIV_START: begin
        // Wait for the volume pipeline to settle before the first job.
        if (wait_r != 2'd0) wait_nxt = wait_r - 2'd1;
        else state_nxt = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (status.div_done) begin
          if (job_r == JOB_DENS) begin
            kind_nxt  = KIND_MIN;
            state_nxt = ST_EMIT;
          end else begin
            job_nxt   = job_r + 3'd1;
            state_nxt = ST_DIV_START;
          end
        end
      end
      ST_EMIT: begin
        if (!ov_r || out_ready) begin
          ov_nxt   = 1'b1;
          kind_nxt = kind_r + 2'd1;
          if (kind_r == KIND_AVERAGES) state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.job  = job_r;
    cmd.kind = kind_r;
    in_ready  = (state_r == ST_IDLE);
    out_valid = ov_r;
    case (state_r)
      ST_IDLE: cmd.accumulate = take && (in_op == OP_POINT);
      ST_DIV_START: cmd.div_start = (wait_r == 2'd0);
      ST_DIV_WAIT: cmd.div_store = status.div_done;
      ST_EMIT: begin
        cmd.out_load = !ov_r || out_ready;
        cmd.clear    = cmd.out_load && (kind_r == KIND_AVERAGES);
      end
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      job_r   <= JOB_CX;
      kind_r  <= KIND_MIN;
      wait_r  <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      job_r   <= job_nxt;
      kind_r  <= kind_nxt;
      wait_r  <= wait_nxt;
      ov_r    <= ov_nxt;
    end
  end
endmodule
`default_nettype wire

// ===== design/point_cloud_statistics.sv =====
// A point beat is added to the sums as it is accepted; a new point is taken
// every cycle while no report is running. A report beat runs seven divisions on one
// shared serial divider once the volume pipeline has settled; its first result beat
// follows the last division, then one result beat per ready cycle.
// No input beat is taken from a report until its last result beat is offered.
// Reset (rst_n low, synchronous) clears all sums, the bounding box, the count
// and the three enable registers; the output channel comes up empty.
`default_nettype none
module point_cloud_statistics #(
  parameter logic [32:0] MAX_POINTS = 33'd16777216
) (
  input  wire logic clk,
  input  wire logic rst_n,
  pcs_stream_if.sink   in_ch,
  pcs_stream_if.source out_ch,
  pcs_stream_if.sink   cfg_ch
);
  import pcs_pkg::*;

  // The counter must hold MAX_POINTS itself.
  localparam int unsigned CW = $clog2(MAX_POINTS + 1) < 25 ? 25 : $clog2(MAX_POINTS + 1);

  // Input beat layout: {view_count, point_scale, confidence, pos_z, pos_y, pos_x, op}.
  logic       in_op;
  logic [31:0] in_x, in_y, in_z, in_scale;
  logic [15:0] in_conf;
  logic [7:0]  in_views;
  assign in_op    = in_ch.data[0];
  assign in_x     = in_ch.data[32:1];
  assign in_y     = in_ch.data[64:33];
  assign in_z     = in_ch.data[96:65];
  assign in_conf  = in_ch.data[112:97];
  assign in_scale = in_ch.data[144:113];
  assign in_views = in_ch.data[152:145];

  // Configuration beats: {value, index}; writes beyond the list are dropped.
  logic use_conf_r, use_scale_r, use_vis_r;
  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      use_conf_r  <= 1'b0;
      use_scale_r <= 1'b0;
      use_vis_r   <= 1'b0;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.data[1:0])
        CFG_USE_CONFIDENCE: use_conf_r  <= cfg_ch.data[2];
        CFG_USE_SCALE:      use_scale_r <= cfg_ch.data[2];
        CFG_USE_VISIBILITY: use_vis_r   <= cfg_ch.data[2];
        default: ;
      endcase
    end
  end

  pcs_cmd_t    cmd;
  pcs_status_t status;
  logic [1:0]  o_kind;
  logic [31:0] o_a, o_b, o_c;
  logic [24:0] o_total;
  logic [47:0] o_dens;
  logic        o_last;

  pcs_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_op(in_op),
    .in_ready(in_ch.ready), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .status(status), .cmd(cmd)
  );

  pcs_datapath #(.CW(CW), .MAX_PTS(MAX_POINTS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .status(status),
    .use_conf(use_conf_r), .use_scale(use_scale_r), .use_vis(use_vis_r),
    .pos_x(in_x), .pos_y(in_y), .pos_z(in_z), .conf(in_conf),
    .pscale(in_scale), .views(in_views),
    .o_kind(o_kind), .o_a(o_a), .o_b(o_b), .o_c(o_c), .o_total(o_total),
    .o_dens(o_dens), .o_last(o_last)
  );

  // Output beat layout: {is_last, density, point_total, value_c, value_b, value_a, kind}.
  assign out_ch.data = {o_last, o_dens, o_total, o_c, o_b, o_a, o_kind};
endmodule
`default_nettype wire

// ===== design/pcs_checker.sv =====
`default_nettype none
`include "assert_macros.svh"
module pcs_checker (
  input wire logic         clk,
  input wire logic         rst_n,
  input wire logic         in_valid,
  input wire logic         in_ready,
  input wire logic         out_valid,
  input wire logic         out_ready,
  input wire logic [171:0] out_data
);
  import pcs_pkg::*;

  `PCS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "result beat changed while stalled")
  `PCS_ASSERT_IMP(a_last_kind, out_valid, out_data[171] == (out_data[1:0] == KIND_AVERAGES), "is_last does not match kind")
  `PCS_ASSERT_IMP(a_no_in_mid_report, out_valid && !out_data[171], !(in_valid && in_ready), "input taken in the middle of a report")
endmodule

bind point_cloud_statistics pcs_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data)
);
`default_nettype wire

// ===== tb/point_cloud_statistics_test.sv =====
`default_nettype none
module point_cloud_statistics_test;
  timeunit 1ns;
  timeprecision 1ps;
  import pcs_pkg::*;

  // Payload layouts, first field in the most significant bits.
  typedef struct packed {
    logic [7:0]         view_count;
    logic [31:0]        point_scale;
    logic [15:0]        confidence;
    logic signed [31:0] pos_z;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_x;
    logic               op;
  } point_beat_t;

  typedef struct packed {
    logic               is_last;
    logic [47:0]        density;
    logic [24:0]        point_total;
    logic signed [31:0] value_c;
    logic signed [31:0] value_b;
    logic signed [31:0] value_a;
    pcs_kind_t          kind;
  } stats_beat_t;

  typedef struct packed {
    logic       value;
    logic [1:0] index;
  } cfg_beat_t;

  localparam longint CLOUD_CAPACITY = 64'd16777216;
  localparam int     CYCLE_LIMIT = 2000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  always #6 clk = ~clk;

  pcs_stream_if #(.W($bits(point_beat_t))) in_ch ();
  pcs_stream_if #(.W($bits(stats_beat_t))) out_ch ();
  pcs_stream_if #(.W($bits(cfg_beat_t)))   cfg_ch ();

  point_cloud_statistics u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source),
    .cfg_ch (cfg_ch.sink)
  );

  // Shadow of the block: enables and the running statistics of the cloud.
  logic   en_conf, en_scale, en_views;
  longint cloud_count;
  longint lo_corner [3];
  longint hi_corner [3];
  longint pos_total [3];
  longint conf_total, scale_total, views_total;

  point_beat_t point_queue [$];
  stats_beat_t expected_stats [$];

  int  send_idle_pct = 17;
  int  recv_idle_pct = 81;
  int  recv_holdoff = 0;
  int  error_count = 0;
  int  cycle_count = 0;

  function automatic void clear_cloud();
    cloud_count = 0;
    for (int k = 0; k < 3; k++) begin
      lo_corner[k] = 0;
      hi_corner[k] = 0;
      pos_total[k] = 0;
    end
    conf_total = 0;
    scale_total = 0;
    views_total = 0;
  endfunction

  // Appends one beat to the sender's queue.
  function automatic void queue_point(point_beat_t b);
    point_queue = {point_queue, b};
  endfunction

  // Points per unit volume: count * 2^64 over the Q48.48 volume, saturated to
  // 48 bits. Volumes below one nano unit count as empty.
  function automatic logic [47:0] cloud_density(longint n, logic [31:0] ex,
                                                 logic [31:0] ey, logic [31:0] ez);
    logic [127:0] vol;
    logic [127:0] quot;
    vol = 128'(ex) * 128'(ey) * 128'(ez);
    if (vol < 128'(VOL_EPS_Q48)) return '0;
    quot = (128'(n) << 64) / vol;
    return (quot > 128'(DENS_MAX)) ? DENS_MAX : quot[47:0];
  endfunction

  // Applies one accepted input beat to the shadow state and queues the
  // results that a report produces.
  function automatic void absorb_beat(point_beat_t b);
    longint      p [3];
    logic [31:0] ext [3];
    logic [47:0] dens;
    longint      avg;
    stats_beat_t r;
    if (b.op == OP_POINT) begin
      // A full cloud ignores further points.
      if (cloud_count >= CLOUD_CAPACITY) return;
      p[0] = b.pos_x;
      p[1] = b.pos_y;
      p[2] = b.pos_z;
      for (int k = 0; k < 3; k++) begin
        if (cloud_count == 0 || p[k] < lo_corner[k]) lo_corner[k] = p[k];
        if (cloud_count == 0 || p[k] > hi_corner[k]) hi_corner[k] = p[k];
        pos_total[k] += p[k];
      end
      conf_total += b.confidence;
      scale_total += b.point_scale;
      views_total += b.view_count;
      cloud_count++;
      return;
    end
    dens = '0;
    if (cloud_count != 0) begin
      for (int k = 0; k < 3; k++) ext[k] = 32'(hi_corner[k] - lo_corner[k]);
      dens = cloud_density(cloud_count, ext[0], ext[1], ext[2]);
    end
    for (int k = 0; k < 4; k++) begin
      r = '0;
      r.kind = pcs_kind_t'(k);
      r.point_total = 25'(cloud_count);
      r.density = dens;
      r.is_last = (k == 3);
      if (cloud_count != 0) begin
        case (r.kind)
          KIND_MIN: begin
            r.value_a = 32'(lo_corner[0]);
            r.value_b = 32'(lo_corner[1]);
            r.value_c = 32'(lo_corner[2]);
          end
          KIND_MAX: begin
            r.value_a = 32'(hi_corner[0]);
            r.value_b = 32'(hi_corner[1]);
            r.value_c = 32'(hi_corner[2]);
          end
          KIND_CENTROID: begin
            // Signed division truncates toward zero, as the block does.
            r.value_a = 32'(pos_total[0] / cloud_count);
            r.value_b = 32'(pos_total[1] / cloud_count);
            r.value_c = 32'(pos_total[2] / cloud_count);
          end
          default: begin
            if (en_conf) r.value_a = 32'(conf_total / cloud_count);
            if (en_scale) begin
              avg = scale_total / cloud_count;
              r.value_b = (avg > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : 32'(avg);
            end
            if (en_views) r.value_c = 32'((views_total << 16) / cloud_count);
          end
        endcase
      end
      expected_stats = {expected_stats, r};
    end
    clear_cloud();
  endfunction

  // Sender: offers queued points whenever the channel is free, idling at the
  // rate of the current phase. Accepted beats feed the shadow model.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.data <= '0;
    end else begin
      if (in_ch.valid && in_ch.ready) absorb_beat(point_beat_t'(in_ch.data));
      if (!in_ch.valid || in_ch.ready) begin
        if (point_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_ch.data <= point_queue.pop_front();
          in_ch.valid <= 1'b1;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off that lets the block back up.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (recv_holdoff > 0) begin
      recv_holdoff <= recv_holdoff - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Result monitor: every accepted beat is matched against the oldest
  // expectation, one field at a time.
  always @(posedge clk) begin
    stats_beat_t got, want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = stats_beat_t'(out_ch.data);
      if (expected_stats.size() == 0) begin
        $display("%0t: result beat with nothing expected: %h", $realtime, got);
        error_count++;
      end else begin
        want = expected_stats.pop_front();
        if (got.kind !== want.kind) begin
          $display("%0t: kind expected %0d actual %0d", $realtime, want.kind, got.kind);
          error_count++;
        end
        if (got.value_a !== want.value_a) begin
          $display("%0t: value_a expected %h actual %h", $realtime, want.value_a,
                   got.value_a);
          error_count++;
        end
        if (got.value_b !== want.value_b) begin
          $display("%0t: value_b expected %h actual %h", $realtime, want.value_b,
                   got.value_b);
          error_count++;
        end
        if (got.value_c !== want.value_c) begin
          $display("%0t: value_c expected %h actual %h", $realtime, want.value_c,
                   got.value_c);
          error_count++;
        end
        if (got.point_total !== want.point_total) begin
          $display("%0t: point_total expected %0d actual %0d", $realtime,
                   want.point_total, got.point_total);
          error_count++;
        end
        if (got.density !== want.density) begin
          $display("%0t: density expected %h actual %h", $realtime, want.density,
                   got.density);
          error_count++;
        end
        if (got.is_last !== want.is_last) begin
          $display("%0t: is_last expected %b actual %b", $realtime, want.is_last,
                   got.is_last);
          error_count++;
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results still expected", $realtime,
               expected_stats.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
  end

  // One register write; the shadow copy changes on the accepting edge.
  task automatic write_reg(logic [1:0] idx, logic val);
    cfg_beat_t c;
    c.index = idx;
    c.value = val;
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= c;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      CFG_USE_CONFIDENCE: en_conf = val;
      CFG_USE_SCALE:      en_scale = val;
      default:            en_views = val;
    endcase
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic set_enables(logic conf, logic scale, logic views);
    write_reg(CFG_USE_CONFIDENCE, conf);
    write_reg(CFG_USE_SCALE, scale);
    write_reg(CFG_USE_VISIBILITY, views);
  endtask

  function automatic point_beat_t make_point(int sx, int sy, int sz,
                                             logic [15:0] conf, logic [31:0] scale,
                                             logic [7:0] views);
    point_beat_t b;
    b.op = OP_POINT;
    b.pos_x = sx;
    b.pos_y = sy;
    b.pos_z = sz;
    b.confidence = conf;
    b.point_scale = scale;
    b.view_count = views;
    return b;
  endfunction

  function automatic point_beat_t make_report();
    logic [159:0] noise;
    point_beat_t  b;
    // The payload of a report is don't-care, so give it random bits.
    noise = {$urandom, $urandom, $urandom, $urandom, $urandom};
    b = noise[$bits(point_beat_t)-1:0];
    b.op = OP_REPORT;
    return b;
  endfunction

  // A random point; a tight cloud keeps the volume small so that the
  // density takes interesting values, a wide one spans the whole range.
  function automatic point_beat_t random_point(bit tight, int base);
    int c [3];
    for (int k = 0; k < 3; k++)
      c[k] = tight ? base + int'($urandom_range(2047)) - 1024 : int'($urandom);
    return make_point(c[0], c[1], c[2], 16'($urandom), $urandom, 8'($urandom));
  endfunction

  // Holds until the sender has handed over every queued beat and every
  // report has drained, then gives the block time to settle.
  task automatic drain();
    while (point_queue.size() != 0 || in_ch.valid || expected_stats.size() != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic queue_random_clouds(int items);
    int budget, n, base;
    bit tight;
    budget = items;
    while (budget > 0) begin
      // Most of the stimulus is whole clouds; now and then an empty report.
      n = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 14);
      tight = $urandom_range(1);
      base = int'($urandom);
      for (int i = 0; i < n; i++) queue_point(random_point(tight, base));
      queue_point(make_report());
      budget -= n + 1;
    end
  endtask

  initial begin
    clear_cloud();
    en_conf = 1'b0;
    en_scale = 1'b0;
    en_views = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part, all attributes on; the sender idles now and then and
    // the receiver mostly stalls.
    set_enables(1'b1, 1'b1, 1'b1);
    // An empty cloud reports all zeros.
    queue_point(make_report());
    // A single point has zero volume, so zero density.
    queue_point(make_point(32'h0001_8000, -32'sd5, 32'h7FFF_FFFF,
                           16'hFFFF, 32'hFFFF_FFFF, 8'hFF));
    queue_point(make_report());
    // Opposite corners of the coordinate range; averages of the largest scale
    // saturate, the widest box gives the smallest density.
    queue_point(make_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                           16'hFFFF, 32'hFFFF_FFFF, 8'hFF));
    queue_point(make_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                           16'hFFFF, 32'hFFFF_FFFF, 8'hFF));
    queue_point(make_point(-32'sd1, 32'sd0, 32'sd1, 16'h0000, 32'h0, 8'h00));
    queue_point(make_report());
    // Eight points in a tiny box just above the volume floor: density saturates.
    for (int i = 0; i < 8; i++)
      queue_point(make_point((i & 1) * 256, (i & 2) * 128, (i & 4) ? 5 : 0,
                             16'(i * 1000), 32'(i << 20), 8'(i)));
    queue_point(make_report());
    // A box under the volume floor reports zero density.
    queue_point(make_point(32'sd10, 32'sd10, 32'sd10, 16'h1, 32'h1, 8'h1));
    queue_point(make_point(32'sd11, 32'sd11, 32'sd11, 16'h2, 32'h2, 8'h2));
    queue_point(make_report());
    drain();

    // Phase one: the sender idles now and then, the receiver mostly stalls.
    set_enables(1'b0, 1'b0, 1'b0);
    send_idle_pct = 17;
    recv_idle_pct = 81;
    queue_random_clouds(100);
    drain();

    // Phase two: the other way round.
    set_enables(1'b1, 1'b0, 1'b1);
    send_idle_pct = 81;
    recv_idle_pct = 17;
    queue_random_clouds(100);
    drain();

    // Phase three: no idling, and a long receiver hold-off while points and
    // reports keep coming, so the block fills and stalls its input.
    set_enables(1'b0, 1'b1, 1'b0);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_random_clouds(100);
    recv_holdoff = 3000;
    drain();

    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ===== filelist.f =====
+incdir+design
design/pcs_pkg.sv
design/pcs_if.sv
design/pcs_divider.sv
design/pcs_datapath.sv
design/pcs_ctrl.sv
design/point_cloud_statistics.sv
design/pcs_checker.sv
tb/point_cloud_statistics_test.sv
